>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define ONF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ONF_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/onf_pkg.sv
// Types and constants of the online normalization forward core.
package onf_pkg;

   typedef logic [3:0] op_type;
   localparam op_type OP_NONE      = 4'd0;
   localparam op_type OP_ACCEPT    = 4'd1;
   localparam op_type OP_LATCH     = 4'd2;
   localparam op_type OP_SQRT_INIT = 4'd3;
   localparam op_type OP_SQRT_STEP = 4'd4;
   localparam op_type OP_SQRT_FIN  = 4'd5;
   localparam op_type OP_DIV_INIT  = 4'd6;
   localparam op_type OP_DIV_STEP  = 4'd7;
   localparam op_type OP_DIV_FIN   = 4'd8;
   localparam op_type OP_MUL_INIT  = 4'd9;
   localparam op_type OP_MUL_STEP  = 4'd10;
   localparam op_type OP_MUL_FIN   = 4'd11;
   localparam op_type OP_WRITE     = 4'd12;
   localparam op_type OP_OUT       = 4'd13;

   // Which division or multiplication the shared units work on.
   typedef logic [3:0] sel_type;
   localparam sel_type SEL_NORM  = 4'd0;  // (x - mean) / scale
   localparam sel_type SEL_MEAN  = 4'd1;  // sum * 256 / D
   localparam sel_type SEL_SQD   = 4'd2;  // sumsq / D
   localparam sel_type SEL_SMSQ  = 4'd3;  // smean^2
   localparam sel_type SEL_D2    = 4'd4;  // diff^2
   localparam sel_type SEL_DA    = 4'd5;  // diff^2 * a
   localparam sel_type SEL_TOMA  = 4'd6;  // (...) * (1-a)
   localparam sel_type SEL_VA    = 4'd7;  // var * a
   localparam sel_type SEL_SVOMA = 4'd8;  // svar * (1-a)
   localparam sel_type SEL_MDOMA = 4'd9;  // |diff| * (1-a)

   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_ELEMENTS = 2'd0;
   localparam csr_idx_type CSR_DECAY    = 2'd1;
   localparam csr_idx_type CSR_EPSILON  = 2'd2;

   localparam logic [5:0] SQRT_STEPS = 6'd25;
   localparam logic [5:0] DIV_STEPS  = 6'd48;
   localparam logic [5:0] MUL_STEPS  = 6'd33;

   localparam logic [31:0] RESET_VAR = 32'h0001_0000;

   typedef struct packed {
      op_type  op;
      sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic count_zero;
      logic closing;
      logic out_free;
   } status_type;

   // Per-channel record held in the state memory.
   typedef struct packed {
      logic signed [31:0] mean;
      logic [31:0]        var_q;
      logic [31:0]        scale;
      logic signed [32:0] sum;
      logic [47:0]        sq;
      logic [15:0]        count;
   } rec_type;

endpackage

>>> sv/onf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module onf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

>>> sv/onf_ctrl.sv
// Controller state machine: sequences the shared sqrt, divide and multiply units.
module onf_ctrl import onf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output logic       req_stall,
   output cmd_type    cmd
);
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_READ    = 4'd1;
   localparam logic [3:0] S_DISP    = 4'd2;
   localparam logic [3:0] S_SQ_INIT = 4'd3;
   localparam logic [3:0] S_SQ_STEP = 4'd4;
   localparam logic [3:0] S_SQ_FIN  = 4'd5;
   localparam logic [3:0] S_DV_INIT = 4'd6;
   localparam logic [3:0] S_DV_STEP = 4'd7;
   localparam logic [3:0] S_DV_FIN  = 4'd8;
   localparam logic [3:0] S_ML_INIT = 4'd9;
   localparam logic [3:0] S_ML_STEP = 4'd10;
   localparam logic [3:0] S_ML_FIN  = 4'd11;
   localparam logic [3:0] S_WRITE   = 4'd12;
   localparam logic [3:0] S_OUT     = 4'd13;

   logic [3:0] state_ff, state_in;
   sel_type    sel_ff, sel_in;
   logic [5:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NONE;
      cmd.sel  = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.op   = OP_LATCH;
            state_in = S_DISP;
         end
         S_DISP: begin
            if (status.is_load) begin
               state_in = S_WRITE;
            end else if (status.count_zero) begin
               state_in = S_SQ_INIT;
            end else begin
               sel_in   = SEL_NORM;
               state_in = S_DV_INIT;
            end
         end
         S_SQ_INIT: begin
            cmd.op   = OP_SQRT_INIT;
            cnt_in   = SQRT_STEPS - 6'd1;
            state_in = S_SQ_STEP;
         end
         S_SQ_STEP: begin
            cmd.op = OP_SQRT_STEP;
            if (cnt_ff == 6'd0) begin
               state_in = S_SQ_FIN;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_SQ_FIN: begin
            cmd.op   = OP_SQRT_FIN;
            sel_in   = SEL_NORM;
            state_in = S_DV_INIT;
         end
         S_DV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = DIV_STEPS - 6'd1;
            state_in = S_DV_STEP;
         end
         S_DV_STEP: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == 6'd0) begin
               state_in = S_DV_FIN;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_DV_FIN: begin
            cmd.op = OP_DIV_FIN;
            if (sel_ff == SEL_NORM) begin
               if (status.closing) begin
                  sel_in   = SEL_MEAN;
                  state_in = S_DV_INIT;
               end else begin
                  state_in = S_WRITE;
               end
            end else if (sel_ff == SEL_MEAN) begin
               sel_in   = SEL_SQD;
               state_in = S_DV_INIT;
            end else begin
               sel_in   = SEL_SMSQ;
               state_in = S_ML_INIT;
            end
         end
         S_ML_INIT: begin
            cmd.op   = OP_MUL_INIT;
            cnt_in   = MUL_STEPS - 6'd1;
            state_in = S_ML_STEP;
         end
         S_ML_STEP: begin
            cmd.op = OP_MUL_STEP;
            if (cnt_ff == 6'd0) begin
               state_in = S_ML_FIN;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_ML_FIN: begin
            cmd.op = OP_MUL_FIN;
            if (sel_ff == SEL_MDOMA) begin
               state_in = S_WRITE;
            end else begin
               sel_in   = sel_ff + 4'd1;
               state_in = S_ML_INIT;
            end
         end
         S_WRITE: begin
            cmd.op   = OP_WRITE;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= SEL_NORM;
         cnt_ff   <= 6'd0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule

>>> sv/onf_dp.sv
// Datapath: channel state memory, sqrt/divide/multiply units, result register.
module onf_dp import onf_pkg::*; #(
   parameter int CHANNELS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_opcode,
   input  logic [5:0]         req_channel,
   input  logic signed [15:0] req_sample_value,
   input  logic signed [31:0] req_init_mean,
   input  logic [31:0]        req_init_var,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_normalized,
   output logic [31:0]        rsp_scale_used,
   output logic               rsp_sample_done,
   output logic signed [31:0] rsp_new_mean,
   output logic [31:0]        rsp_new_var
);
   localparam int DEPTH = (CHANNELS < 64) ? CHANNELS : 64;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = $bits(rec_type);

   // channel number folded onto the channels that exist
   logic [AW-1:0] chmap [64];
   for (genvar gi = 0; gi < 64; gi++) begin : g_map
      assign chmap[gi] = AW'(gi % CHANNELS);
   end

   // configuration
   logic [15:0] epr_ff, decay_ff, eps_ff;
   logic [DEPTH-1:0] valid_ff;
   logic rsp_valid_ff;

   // item and channel working state
   logic [AW-1:0]      ch_ff;
   logic               opc_ff;
   logic signed [15:0] x_ff;
   logic [31:0]        im_ff, iv_ff;
   logic signed [31:0] mean_ff, mean_in;
   logic [31:0]        var_ff, var_in;
   logic [31:0]        scale_ff, scale_in;
   logic signed [32:0] sum_ff, sum_in;
   logic [47:0]        sq_ff, sq_in;
   logic [15:0]        count_ff, count_in;
   logic               close_ff, close_in;
   // sqrt unit
   logic [49:0] sqv_ff, sqv_in;
   logic [27:0] rem_ff, rem_in;
   logic [24:0] root_ff, root_in;
   // divider
   logic [47:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in, rmd_ff, rmd_in;
   logic        neg_ff, neg_in, nz_ff, nz_in;
   // multiplier
   logic [49:0] ma_ff, ma_in;
   logic [32:0] mb_ff, mb_in;
   logic [66:0] prod_ff, prod_in;
   // intermediate results
   logic [15:0]        norm_ff, norm_in;
   logic signed [40:0] smean_ff, smean_in;
   logic [47:0]        sqd_ff, sqd_in, svar_ff, svar_in, d2q_ff, d2q_in, t_ff, t_in;
   logic [63:0]        acc_ff, acc_in;
   logic [31:0]        nv_ff, nv_in, nm_ff, nm_in;

   rec_type ram_rd, ram_wr;
   logic [RW-1:0] ram_rd_bits;
   assign ram_rd = rec_type'(ram_rd_bits);

   onf_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.op == OP_WRITE),
      .wr_addr (ch_ff),
      .wr_data (ram_wr),
      .rd_en   (cmd.op == OP_ACCEPT),
      .rd_addr (chmap[req_channel]),
      .rd_data (ram_rd_bits)
   );

   // shared arithmetic
   logic [15:0]        dlen;
   logic [16:0]        oma, cnt_next;
   logic               closing;
   logic signed [32:0] ndiff;
   logic [40:0]        nnum, mnum, nmag, mmag;
   logic signed [41:0] smd;
   logic [41:0]        amd;
   logic [40:0]        smag;
   logic [48:0]        qadj;
   logic [27:0]        rem_sh, trial;
   logic [32:0]        dr;
   logic [66:0]        prod_step;
   logic [67:0]        sdiff;
   logic [63:0]        s64, nvs;
   logic [64:0]        up;
   logic [49:0]        nms;
   logic signed [31:0] xsq;

   always_comb begin
      dlen     = (epr_ff == 16'd0) ? 16'd1 : epr_ff;
      oma      = 17'h10000 - {1'b0, decay_ff};
      cnt_next = {1'b0, count_ff} + 17'd1;
      closing  = cnt_next >= {1'b0, dlen};
      ndiff    = {{9{x_ff[15]}}, x_ff, 8'd0} - {mean_ff[31], mean_ff};
      nnum     = {ndiff, 8'd0};
      mnum     = {sum_ff, 8'd0};
      nmag     = nnum[40] ? (41'd0 - nnum) : nnum;
      mmag     = mnum[40] ? (41'd0 - mnum) : mnum;
      smd      = {smean_ff[40], smean_ff} - {{10{mean_ff[31]}}, mean_ff};
      amd      = smd[41] ? (42'd0 - smd) : smd;
      smag     = smean_ff[40] ? (41'd0 - smean_ff) : smean_ff;
      qadj     = {1'b0, quo_ff} + {48'd0, (neg_ff && (rmd_ff != 32'd0))};
      rem_sh   = {rem_ff[25:0], sqv_ff[49:48]};
      trial    = {1'b0, root_ff, 2'b01};
      dr       = {rmd_ff, dvd_ff[47]};
      prod_step = {prod_ff[65:0], 1'b0} + (mb_ff[32] ? {17'd0, ma_ff} : 67'd0);
      sdiff    = {20'd0, sqd_ff} - {17'd0, prod_ff[66:16]};
      s64      = acc_ff + prod_ff[63:0];
      nvs      = {16'd0, s64[63:16]} + {16'd0, t_ff};
      up       = smd[41] ? ({1'b0, prod_ff[63:0]} + 65'd65535) : {1'b0, prod_ff[63:0]};
      nms      = {{18{mean_ff[31]}}, mean_ff}
                 + (smd[41] ? (50'd0 - {1'b0, up[64:16]}) : {1'b0, up[64:16]});
      xsq      = x_ff * x_ff;
   end

   always_comb begin
      mean_in  = mean_ff;   var_in   = var_ff;   scale_in = scale_ff;
      sum_in   = sum_ff;    sq_in    = sq_ff;    count_in = count_ff;
      close_in = close_ff;
      sqv_in   = sqv_ff;    rem_in   = rem_ff;   root_in  = root_ff;
      dvd_in   = dvd_ff;    dvs_in   = dvs_ff;   quo_in   = quo_ff;
      rmd_in   = rmd_ff;    neg_in   = neg_ff;   nz_in    = nz_ff;
      ma_in    = ma_ff;     mb_in    = mb_ff;    prod_in  = prod_ff;
      norm_in  = norm_ff;   smean_in = smean_ff; sqd_in   = sqd_ff;
      svar_in  = svar_ff;   d2q_in   = d2q_ff;   t_in     = t_ff;
      acc_in   = acc_ff;    nv_in    = nv_ff;    nm_in    = nm_ff;
      unique case (cmd.op)
         OP_LATCH: begin
            close_in = 1'b0;
            norm_in  = 16'd0;
            if (valid_ff[ch_ff]) begin
               mean_in  = ram_rd.mean;  var_in = ram_rd.var_q; scale_in = ram_rd.scale;
               sum_in   = ram_rd.sum;   sq_in  = ram_rd.sq;    count_in = ram_rd.count;
            end else begin
               mean_in  = 32'sd0;  var_in = RESET_VAR; scale_in = 32'd0;
               sum_in   = 33'sd0;  sq_in  = 48'd0;     count_in = 16'd0;
            end
         end
         OP_SQRT_INIT: begin
            sqv_in  = {1'b0, ({1'b0, var_ff} + {17'd0, eps_ff}), 16'd0};
            rem_in  = 28'd0;
            root_in = 25'd0;
         end
         OP_SQRT_STEP: begin
            sqv_in = {sqv_ff[47:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[23:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[23:0], 1'b0};
            end
         end
         OP_SQRT_FIN: begin
            scale_in = {7'd0, root_ff};
         end
         OP_DIV_INIT: begin
            quo_in = 48'd0;
            rmd_in = 32'd0;
            case (cmd.sel)
               SEL_NORM: begin
                  dvd_in = {7'd0, nmag}; dvs_in = scale_ff;
                  neg_in = nnum[40];     nz_in  = (nnum != 41'd0);
               end
               SEL_MEAN: begin
                  dvd_in = {7'd0, mmag}; dvs_in = {16'd0, dlen};
                  neg_in = mnum[40];     nz_in  = (mnum != 41'd0);
               end
               default: begin
                  dvd_in = sq_ff; dvs_in = {16'd0, dlen};
                  neg_in = 1'b0;  nz_in  = (sq_ff != 48'd0);
               end
            endcase
         end
         OP_DIV_STEP: begin
            dvd_in = {dvd_ff[46:0], 1'b0};
            if (dr >= {1'b0, dvs_ff}) begin
               rmd_in = 32'(dr - {1'b0, dvs_ff});
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rmd_in = dr[31:0];
               quo_in = {quo_ff[46:0], 1'b0};
            end
         end
         OP_DIV_FIN: begin
            case (cmd.sel)
               SEL_NORM: begin
                  if (scale_ff == 32'd0) begin
                     norm_in = !nz_ff ? 16'd0 : (neg_ff ? 16'h8000 : 16'h7FFF);
                  end else if (neg_ff) begin
                     norm_in = (qadj > 49'd32768) ? 16'h8000 : (16'd0 - qadj[15:0]);
                  end else begin
                     norm_in = (quo_ff > 48'd32767) ? 16'h7FFF : quo_ff[15:0];
                  end
                  sum_in   = sum_ff + {{17{x_ff[15]}}, x_ff};
                  sq_in    = sq_ff + {16'd0, xsq[31:0]};
                  count_in = cnt_next[15:0];
                  close_in = closing;
               end
               SEL_MEAN: begin
                  smean_in = neg_ff ? (41'd0 - qadj[40:0]) : qadj[40:0];
               end
               default: begin
                  sqd_in = quo_ff;
               end
            endcase
         end
         OP_MUL_INIT: begin
            prod_in = 67'd0;
            case (cmd.sel)
               SEL_SMSQ:  begin ma_in = {9'd0, smag};     mb_in = smag[32:0];       end
               SEL_D2:    begin ma_in = {8'd0, amd};      mb_in = amd[32:0];        end
               SEL_DA:    begin ma_in = {2'd0, d2q_ff};   mb_in = {17'd0, decay_ff}; end
               SEL_TOMA:  begin ma_in = {2'd0, t_ff};     mb_in = {16'd0, oma};      end
               SEL_VA:    begin ma_in = {18'd0, var_ff};  mb_in = {17'd0, decay_ff}; end
               SEL_SVOMA: begin ma_in = {2'd0, svar_ff};  mb_in = {16'd0, oma};      end
               default:   begin ma_in = {8'd0, amd};      mb_in = {16'd0, oma};      end
            endcase
         end
         OP_MUL_STEP: begin
            prod_in = prod_step;
            mb_in   = {mb_ff[31:0], 1'b0};
         end
         OP_MUL_FIN: begin
            case (cmd.sel)
               SEL_SMSQ:  svar_in = sdiff[67] ? 48'd0 : sdiff[47:0];
               SEL_D2:    d2q_in  = prod_ff[63:16];
               SEL_DA:    t_in    = prod_ff[63:16];
               SEL_TOMA:  t_in    = prod_ff[63:16];
               SEL_VA:    acc_in  = prod_ff[63:0];
               SEL_SVOMA: nv_in   = (nvs[63:32] != 32'd0) ? 32'hFFFF_FFFF : nvs[31:0];
               default: begin
                  if (!nms[49] && (nms[48:31] != 18'd0)) begin
                     nm_in = 32'h7FFF_FFFF;
                  end else if (nms[49] && (nms[48:31] != 18'h3FFFF)) begin
                     nm_in = 32'h8000_0000;
                  end else begin
                     nm_in = nms[31:0];
                  end
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // record written back to the state memory
   always_comb begin
      ram_wr.scale = scale_ff;
      if (opc_ff) begin
         ram_wr.mean  = im_ff;  ram_wr.var_q = iv_ff;
         ram_wr.sum   = 33'sd0; ram_wr.sq    = 48'd0; ram_wr.count = 16'd0;
      end else if (close_ff) begin
         ram_wr.mean  = nm_ff;  ram_wr.var_q = nv_ff;
         ram_wr.sum   = 33'sd0; ram_wr.sq    = 48'd0; ram_wr.count = 16'd0;
      end else begin
         ram_wr.mean  = mean_ff; ram_wr.var_q = var_ff;
         ram_wr.sum   = sum_ff;  ram_wr.sq    = sq_ff;  ram_wr.count = count_ff;
      end
   end

   assign status.is_load    = opc_ff;
   assign status.count_zero = (count_ff == 16'd0);
   assign status.closing    = closing;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         epr_ff       <= 16'd1;
         decay_ff     <= 16'd65470;
         eps_ff       <= 16'd1;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_ELEMENTS: epr_ff   <= csr_wdata;
               CSR_DECAY:    decay_ff <= csr_wdata;
               CSR_EPSILON:  eps_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.op == OP_WRITE) begin
            valid_ff[ch_ff] <= 1'b1;
         end
         if (cmd.op == OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ACCEPT) begin
         ch_ff  <= chmap[req_channel];
         opc_ff <= req_opcode;
         x_ff   <= req_sample_value;
         im_ff  <= req_init_mean;
         iv_ff  <= req_init_var;
      end
      if (cmd.op == OP_OUT) begin
         rsp_normalized  <= opc_ff ? 16'sd0 : norm_ff;
         rsp_scale_used  <= opc_ff ? 32'd0 : scale_ff;
         rsp_sample_done <= !opc_ff && close_ff;
         rsp_new_mean    <= (!opc_ff && close_ff) ? nm_ff : 32'sd0;
         rsp_new_var     <= (!opc_ff && close_ff) ? nv_ff : 32'd0;
      end
      mean_ff  <= mean_in;  var_ff   <= var_in;   scale_ff <= scale_in;
      sum_ff   <= sum_in;   sq_ff    <= sq_in;    count_ff <= count_in;
      close_ff <= close_in;
      sqv_ff   <= sqv_in;   rem_ff   <= rem_in;   root_ff  <= root_in;
      dvd_ff   <= dvd_in;   dvs_ff   <= dvs_in;   quo_ff   <= quo_in;
      rmd_ff   <= rmd_in;   neg_ff   <= neg_in;   nz_ff    <= nz_in;
      ma_ff    <= ma_in;    mb_ff    <= mb_in;    prod_ff  <= prod_in;
      norm_ff  <= norm_in;  smean_ff <= smean_in; sqd_ff   <= sqd_in;
      svar_ff  <= svar_in;  d2q_ff   <= d2q_in;   t_ff     <= t_in;
      acc_ff   <= acc_in;   nv_ff    <= nv_in;    nm_ff    <= nm_in;
   end
endmodule

>>> sv/online_norm_forward_core.sv
// Top level of the online normalization forward core.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  req      | valid/stall, opcode, channel, value,    | in
//           | init_mean, init_var                     |
//  rsp      | valid/stall, normalized, scale_used,    | out
//           | sample_done, new_mean, new_var          |
//  csr      | write_en, index, wdata                  | in
//
// One item at a time. A load only writes the channel record and answers. A data
// element inside a sample runs the 48-step shared divider; the first element of a
// sample also runs the 25-step square root first. The closing element adds two more
// divides and seven 33-step multiplies on the shared shift-add multiplier.
// Reset is synchronous; it restores registers and marks all channels unwritten.
// A stalled result is held in the output register while the next item is
// already being processed; req_stall is low only when the core is idle.
module online_norm_forward_core import onf_pkg::*; #(
   parameter int CHANNELS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_opcode,
   input  logic [5:0]         req_channel,
   input  logic signed [15:0] req_sample_value,
   input  logic signed [31:0] req_init_mean,
   input  logic [31:0]        req_init_var,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_normalized,
   output logic [31:0]        rsp_scale_used,
   output logic               rsp_sample_done,
   output logic signed [31:0] rsp_new_mean,
   output logic [31:0]        rsp_new_var,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   cmd_type    cmd;
   status_type status;

   // Sequencer: walks sqrt (first element only) -> normalize divide -> (close: stats
   // divides and multiplies) -> write back -> result; a load goes straight to write back.
   onf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // All arithmetic, channel memory and the output register.
   onf_dp #(.CHANNELS(CHANNELS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_channel      (req_channel),
      .req_sample_value (req_sample_value),
      .req_init_mean    (req_init_mean),
      .req_init_var     (req_init_var),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_normalized   (rsp_normalized),
      .rsp_scale_used   (rsp_scale_used),
      .rsp_sample_done  (rsp_sample_done),
      .rsp_new_mean     (rsp_new_mean),
      .rsp_new_var      (rsp_new_var)
   );
endmodule

>>> sv/onf_checker.sv
// Port-level checks for the online normalization forward core, with bind.
`include "assert_macros.svh"

module onf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_normalized,
   input logic [31:0]        rsp_scale_used,
   input logic               rsp_sample_done,
   input logic signed [31:0] rsp_new_mean,
   input logic [31:0]        rsp_new_var
);
   // core works on one item at a time
   `ONF_ASSERT(a_busy_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall, "accepted item did not make the core busy")
   // stats fields are zero unless a sample closed
   `ONF_ASSERT(a_stats_zero, clock, reset, (rsp_valid && !rsp_sample_done) |-> (rsp_new_mean == 32'sd0 && rsp_new_var == 32'd0), "stats reported without a closed sample")
   // stalled result holds
   `ONF_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_normalized) && $stable(rsp_scale_used) && $stable(rsp_new_mean) && $stable(rsp_new_var)), "stalled result changed")
   // nothing pending right after reset
   `ONF_ASSERT_NR(a_reset_clear, clock, reset |=> !rsp_valid, "result valid after reset")
endmodule

bind online_norm_forward_core onf_checker u_onf_checker (.*);

>>> bench/tb_top.sv
// Self-checking testbench of the online normalization forward core.
`timescale 1ns / 1ps

module tb_top;
   import onf_pkg::*;

   localparam int NCH = 64;
   localparam logic OPC_DATA = 1'b0;
   localparam logic OPC_LOAD = 1'b1;

   typedef struct packed {
      logic signed [15:0] normalized;
      logic [31:0]        scale_used;
      logic               sample_done;
      logic signed [31:0] new_mean;
      logic [31:0]        new_var;
   } norm_out_type;

   typedef struct {
      logic               opcode;
      logic [5:0]         channel;
      logic signed [15:0] value;
      logic signed [31:0] init_mean;
      logic [31:0]        init_var;
      bit                 typed;      // expected result given in the row
      norm_out_type       typed_out;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_opcode = 1'b0;
   logic [5:0]         req_channel = '0;
   logic signed [15:0] req_sample_value = '0;
   logic signed [31:0] req_init_mean = '0;
   logic [31:0]        req_init_var = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_normalized;
   logic [31:0]        rsp_scale_used;
   logic               rsp_sample_done;
   logic signed [31:0] rsp_new_mean;
   logic [31:0]        rsp_new_var;
   logic               csr_write_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   online_norm_forward_core #(.CHANNELS(NCH)) u_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor copy of the per-channel statistics and the registers.
   logic [15:0]        cfg_len;
   logic [15:0]        cfg_decay;
   logic [15:0]        cfg_eps;
   logic signed [31:0] st_mean  [NCH];
   logic [31:0]        st_var   [NCH];
   logic [31:0]        st_scale [NCH];
   longint             st_sum   [NCH];
   longint unsigned    st_sq    [NCH];
   int unsigned        st_cnt   [NCH];

   norm_out_type expected_q[$];
   int        errors = 0;
   bit        quiet_tail = 0;     // no idling near the end
   bit        hold_rsp = 0;       // long receiver hold-off request

   function automatic longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   task automatic stats_reset();
      cfg_len = 16'd1;
      cfg_decay = 16'd65470;
      cfg_eps = 16'd1;
      for (int i = 0; i < NCH; i++) begin
         st_mean[i] = 0; st_var[i] = RESET_VAR; st_scale[i] = 0;
         st_sum[i] = 0; st_sq[i] = 0; st_cnt[i] = 0;
      end
   endtask

   // Works out the result of one item and advances the statistics.
   function automatic norm_out_type normalize_item(logic op, logic [5:0] chn,
         logic signed [15:0] xv, logic signed [31:0] im, logic [31:0] iv);
      norm_out_type r;
      int ch;
      longint x, diff, q, smean, svar, md, nm;
      longint unsigned a, oma, amd, d2q, t, nv, dd;
      r = '0;
      ch = chn % NCH;
      if (op == OPC_LOAD) begin
         st_mean[ch] = im; st_var[ch] = iv;
         st_sum[ch] = 0; st_sq[ch] = 0; st_cnt[ch] = 0;
         return r;
      end
      x = xv;
      if (st_cnt[ch] == 0)
         st_scale[ch] = 32'(int_sqrt((longint'(st_var[ch]) + cfg_eps) << 16));
      diff = x * 256 - longint'(st_mean[ch]);
      if (st_scale[ch] == 0) q = diff > 0 ? 32767 : (diff < 0 ? -32768 : 0);
      else q = fdiv(diff * 256, longint'(st_scale[ch]));
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.normalized = q[15:0];
      r.scale_used = st_scale[ch];
      st_sum[ch] += x;
      st_sq[ch] += longint'(x * x);
      st_cnt[ch]++;
      dd = (cfg_len == 0) ? 1 : cfg_len;
      if (st_cnt[ch] >= dd) begin
         smean = fdiv(st_sum[ch] * 256, longint'(dd));
         svar = longint'(st_sq[ch] / dd) - (smean * smean) / 65536;
         if (svar < 0) svar = 0;
         a = cfg_decay;
         oma = 65536 - a;
         md = smean - longint'(st_mean[ch]);
         amd = md < 0 ? -md : md;
         d2q = (amd * amd) >> 16;
         t = (((d2q * a) >> 16) * oma) >> 16;
         nv = ((a * st_var[ch] + oma * longint'(svar)) >> 16) + t;
         if (nv > 64'hFFFF_FFFF) nv = 64'hFFFF_FFFF;
         nm = longint'(st_mean[ch]) + fdiv(longint'(oma) * md, 65536);
         if (nm > 64'sh7FFF_FFFF) nm = 64'sh7FFF_FFFF;
         if (nm < -64'sh8000_0000) nm = -64'sh8000_0000;
         st_mean[ch] = nm[31:0]; st_var[ch] = nv[31:0];
         st_sum[ch] = 0; st_sq[ch] = 0; st_cnt[ch] = 0;
         r.sample_done = 1'b1;
         r.new_mean = nm[31:0];
         r.new_var = nv[31:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Result checking against the oldest expectation.
   always @(posedge clock) begin
      norm_out_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            w = expected_q.pop_front();
            if (rsp_normalized !== w.normalized)
               report_mismatch("normalized", rsp_normalized, w.normalized);
            if (rsp_scale_used !== w.scale_used)
               report_mismatch("scale_used", rsp_scale_used, w.scale_used);
            if (rsp_sample_done !== w.sample_done)
               report_mismatch("sample_done", rsp_sample_done, w.sample_done);
            if (rsp_new_mean !== w.new_mean)
               report_mismatch("new_mean", rsp_new_mean, w.new_mean);
            if (rsp_new_var !== w.new_var)
               report_mismatch("new_var", rsp_new_var, w.new_var);
         end
      end
   end

   // Receiver: random stall bursts, or a long hold-off on request.
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_rsp = 0;
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   // Sends one item and records its expected result once accepted.
   // valid stays high after the accept; the next item or drain() takes it over.
   task automatic send_item(stim_row_type row);
      norm_out_type w;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= row.opcode;
      req_channel <= row.channel;
      req_sample_value <= row.value;
      req_init_mean <= row.init_mean;
      req_init_var <= row.init_var;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      w = normalize_item(row.opcode, row.channel, row.value, row.init_mean, row.init_var);
      if (row.typed) w = row.typed_out;
      expected_q.push_back(w);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_q.size() != 0)
         report_mismatch("missing items", expected_q.size(), 0);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [15:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_ELEMENTS: cfg_len = val;
         CSR_DECAY:    cfg_decay = val;
         default:      cfg_eps = val;
      endcase
      @(posedge clock);
   endtask

   function automatic stim_row_type data_row(logic [5:0] c, logic signed [15:0] v);
      stim_row_type r;
      r = '{default: '0};
      r.opcode = OPC_DATA; r.channel = c; r.value = v;
      return r;
   endfunction

   function automatic stim_row_type load_row(logic [5:0] c, logic signed [31:0] m,
         logic [31:0] v);
      stim_row_type r;
      r = '{default: '0};
      r.opcode = OPC_LOAD; r.channel = c; r.init_mean = m; r.init_var = v;
      r.typed = 1'b1;                 // a load always answers with zeros
      return r;
   endfunction

   function automatic stim_row_type random_row(int nch);
      stim_row_type r;
      int k;
      k = $urandom_range(0, 9);
      if (k == 0)
         r = load_row(6'($urandom_range(0, nch - 1)), $urandom,
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40_0000));
      else if (k == 1)
         r = data_row(6'($urandom_range(0, 63)), 16'($urandom));
      else
         r = data_row(6'($urandom_range(0, nch - 1)),
                      16'($urandom_range(0, 3) == 0 ? $urandom
                                                    : $signed($urandom_range(0, 4095)) - 2048));
      return r;
   endfunction

   stim_row_type directed[$];

   initial begin
      stim_row_type row;
      stats_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset state, value extremes, loads, highest channel.
      row = data_row(6'd0, 16'sd0);
      row.typed = 1;   // var 1.0 + eps: scale 65536, sample of one closes
      row.typed_out = '{normalized: 16'sd0, scale_used: 32'd65536, sample_done: 1'b1,
                        new_mean: 32'sd0, new_var: 32'd65470};
      directed.push_back(row);
      directed.push_back(data_row(6'd1, 16'sh7FFF));
      directed.push_back(data_row(6'd2, 16'sh8000));
      directed.push_back(load_row(6'd3, 32'sh7FFF_FFFF, 32'hFFFF_FFFF));
      directed.push_back(data_row(6'd3, 16'sh8000));
      directed.push_back(load_row(6'd4, 32'sh8000_0000, 32'd0));
      directed.push_back(data_row(6'd4, 16'sh7FFF));
      directed.push_back(load_row(6'd5, 32'sd256, 32'd0));
      directed.push_back(data_row(6'd5, 16'sd1));
      directed.push_back(data_row(6'd63, 16'sh5555));
      directed.push_back(data_row(6'd63, 16'shAAAA));
      foreach (directed[i]) send_item(directed[i]);
      drain();

      // Zero scale needs epsilon 0, zero-variance channel.
      write_reg(CSR_EPSILON, 16'd0);
      write_reg(CSR_DECAY, 16'd0);
      directed.delete();
      directed.push_back(load_row(6'd6, 32'sd0, 32'd0));
      directed.push_back(data_row(6'd6, 16'sd5));
      directed.push_back(load_row(6'd6, 32'sd0, 32'd0));
      directed.push_back(data_row(6'd6, -16'sd5));
      directed.push_back(load_row(6'd6, 32'sd0, 32'd0));
      directed.push_back(data_row(6'd6, 16'sd0));
      foreach (directed[i]) send_item(directed[i]);
      drain();

      // Zero length treated as one, then a length lowered mid-sample.
      write_reg(CSR_ELEMENTS, 16'd0);
      write_reg(CSR_DECAY, 16'hFFFF);
      write_reg(CSR_EPSILON, 16'hFFFF);
      send_item(data_row(6'd7, 16'sd300));
      drain();
      write_reg(CSR_ELEMENTS, 16'd5);
      send_item(data_row(6'd8, 16'sd10));
      send_item(data_row(6'd8, 16'sd20));
      send_item(data_row(6'd8, 16'sd30));
      send_item(load_row(6'd9, 32'sd100, 32'd65536));
      send_item(data_row(6'd9, 16'sd40));
      drain();
      write_reg(CSR_ELEMENTS, 16'd2);
      send_item(data_row(6'd8, 16'sd40));
      drain();

      // Random phases over several register settings; few channels in most phases so samples close.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(CSR_ELEMENTS, 16'd1); write_reg(CSR_DECAY, 16'd65470);
                     write_reg(CSR_EPSILON, 16'd1); end
            1: begin write_reg(CSR_ELEMENTS, 16'd3); write_reg(CSR_DECAY, 16'd32768);
                     write_reg(CSR_EPSILON, 16'd0); end
            2: begin write_reg(CSR_ELEMENTS, 16'd4); write_reg(CSR_DECAY, 16'd0);
                     write_reg(CSR_EPSILON, 16'd100); end
            3: begin write_reg(CSR_ELEMENTS, 16'd2); write_reg(CSR_DECAY, 16'hFFFF);
                     write_reg(CSR_EPSILON, 16'hFFFF); end
            4: begin write_reg(CSR_ELEMENTS, 16'hFFFF); write_reg(CSR_DECAY, 16'd1000);
                     write_reg(CSR_EPSILON, 16'd7); end
            default: begin write_reg(CSR_ELEMENTS, 16'd2); write_reg(CSR_DECAY, 16'd60000);
                     write_reg(CSR_EPSILON, 16'd1); end
         endcase
         if (ph == 1) hold_rsp = 1;    // receiver holds off, sender keeps offering
         if (ph == 5) quiet_tail = 1;
         for (int i = 0; i < 155; i++) send_item(random_row(ph == 4 ? 64 : 4));
         if (ph == 3) drain();         // sender pauses until all results are in
         drain();
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> online_norm_forward_core.f
+incdir+sv
sv/onf_pkg.sv
sv/onf_ram.sv
sv/onf_ctrl.sv
sv/onf_dp.sv
sv/online_norm_forward_core.sv
sv/onf_checker.sv
bench/tb_top.sv
